### src/ivf_pkg.sv
// ----------------------------------------------------------------------------
// ivf_pkg: shared types and constants of the IVF container parser
// Record and event formats, record kinds, error codes and header layout.
// ----------------------------------------------------------------------------
package ivf_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MAGIC     = 3'd1,
    ERR_HEADER    = 3'd2,
    ERR_FHDR      = 3'd3,
    ERR_FSIZE     = 3'd4,
    ERR_NO_FRAMES = 3'd5
  } err_t;

  // "DKIF", first byte in the low lane
  localparam logic [31:0] MAGIC = 32'h4649_4B44;

  // field index marks inside the file header and the frame header
  localparam logic [4:0] IDX_MAGIC_END = 5'd4;   // magic bytes 0..3
  localparam logic [4:0] IDX_HB_END    = 5'd28;  // stored header bytes 4..27
  localparam logic [4:0] IDX_HDR_LAST  = 5'd31;  // final byte of 32-byte header
  localparam logic [4:0] IDX_LEN_END   = 5'd4;   // frame size bytes 0..3
  localparam logic [4:0] IDX_FHDR_LAST = 5'd11;  // final byte of 12-byte header

  localparam logic [15:0] HDR_LEN = 16'd32;
  localparam int          HB_DEPTH = 24;

  localparam int EVQ_DEPTH = 4;

  localparam int TDATA_W = 296;

  typedef struct packed {
    kind_t       kind;
    err_t        err;
    logic [31:0] codec_fourcc;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [31:0] time_rate;
    logic [31:0] time_scale;
    logic [31:0] declared_count;
    logic [31:0] payload_offset;
    logic [31:0] payload_size;
    logic [63:0] frame_timestamp;
  } rec_t;

  // one queue entry: a record, and whether an end record follows it
  typedef struct packed {
    rec_t rec;
    logic pair;
  } evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } evq_stat_t;

endpackage

### src/ivf_container_parser_top.sv
// Path: a record word is queued when the byte that causes it is accepted and
//   is then loaded into the output register; a file's end record follows its frame.
// Throughput: one byte per cycle; in_tready drops only while the four-entry event
//   queue between the parser and the output register is full.
// Reset: synchronous, active low; clears parser state, queue pointers and the
//   output valid, with no clearing pass.
// ----------------------------------------------------------------------------
// ivf_container_parser_top: IVF container parser
// Byte stream in, header, frame, end and error records out.
// ----------------------------------------------------------------------------
module ivf_container_parser_top #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // data_byte
  input  logic                        in_tlast,   // end_of_data
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // error_code, codec_fourcc, frame_width, frame_height, time_rate, time_scale,
  // declared_count, payload_offset, payload_size, frame_timestamp, zero fill
  output logic [ivf_pkg::TDATA_W-1:0] out_tdata,
  output logic [1:0]                  out_tuser,  // record_kind
  output logic                        out_tlast   // last_of_run
);

  ivf_pkg::evq_stat_t q_stat;
  ivf_pkg::evt_t      push_evt;
  ivf_pkg::evt_t      head;
  ivf_pkg::rec_t      out_rec;
  logic               push;
  logic               pop;

  ivf_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .q_stat   (q_stat),
    .push     (push),
    .evt      (push_evt)
  );

  ivf_evq u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_evt(push_evt),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  ivf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_rec   (out_rec),
    .out_last  (out_tlast)
  );

  assign out_tuser = out_rec.kind;
  assign out_tdata = {5'd0,
                      out_rec.frame_timestamp,
                      out_rec.payload_size,
                      out_rec.payload_offset,
                      out_rec.declared_count,
                      out_rec.time_scale,
                      out_rec.time_rate,
                      out_rec.frame_height,
                      out_rec.frame_width,
                      out_rec.codec_fourcc,
                      out_rec.err};

endmodule

### src/ivf_front.sv
// ----------------------------------------------------------------------------
// ivf_front: byte-level IVF parser
// Walks the file header, skip area, frame headers and payloads one byte per
// cycle unless the queue is full; pushes one event per record-producing byte.
// ----------------------------------------------------------------------------
module ivf_front #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  ivf_pkg::evq_stat_t  q_stat,
  output logic                push,
  output ivf_pkg::evt_t       evt
);

  localparam int OW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_SKIP,
    PH_FHDR,
    PH_PAY,
    PH_DRAIN
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [4:0]             fidx_r, fidx_nxt;
  logic [15:0]            hlen_r, hlen_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [31:0]            flen_r, flen_nxt;
  logic [63:0]            ftime_r, ftime_nxt;
  logic [31:0]            rem_r, rem_nxt;
  logic                   seen_r, seen_nxt;
  logic [7:0]             hb_r [ivf_pkg::HB_DEPTH];

  logic                   acc;
  logic                   hb_we;
  logic [4:0]             hb_addr;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [OW-1:0]          off_w;
  logic [31:0]            rem_dec;
  logic                   evt_vld;
  logic                   fail_en;
  ivf_pkg::err_t          fail_code;
  logic                   do_reset;
  logic [15:0]            h_ver, h_len, h_w, h_h;
  logic [31:0]            h_cc, h_rate, h_scale, h_cnt;
  logic                   h_bad;

  assign in_tready = !q_stat.full;
  assign acc       = in_tvalid && in_tready;
  assign push      = acc && evt_vld;

  assign pos_inc = pos_r + 1'b1;
  assign off_w   = OW'(pos_inc) - OW'(flen_r);
  assign rem_dec = rem_r - 32'd1;

  assign h_ver   = {hb_r[1], hb_r[0]};
  assign h_len   = {hb_r[3], hb_r[2]};
  assign h_cc    = {hb_r[7], hb_r[6], hb_r[5], hb_r[4]};
  assign h_w     = {hb_r[9], hb_r[8]};
  assign h_h     = {hb_r[11], hb_r[10]};
  assign h_rate  = {hb_r[15], hb_r[14], hb_r[13], hb_r[12]};
  assign h_scale = {hb_r[19], hb_r[18], hb_r[17], hb_r[16]};
  assign h_cnt   = {hb_r[23], hb_r[22], hb_r[21], hb_r[20]};
  assign h_bad   = (h_ver != '0) || (h_len < ivf_pkg::HDR_LEN) || (h_w == '0) ||
                   (h_h == '0) || (h_rate == '0) || (h_scale == '0);

  assign hb_we   = acc && (phase_r == PH_HEAD) && (fidx_r >= ivf_pkg::IDX_MAGIC_END) &&
                   (fidx_r < ivf_pkg::IDX_HB_END);
  assign hb_addr = fidx_r - ivf_pkg::IDX_MAGIC_END;

  always_comb begin
    phase_nxt = phase_r;
    fidx_nxt  = fidx_r;
    hlen_nxt  = hlen_r;
    pos_nxt   = pos_inc;
    flen_nxt  = flen_r;
    ftime_nxt = ftime_r;
    rem_nxt   = rem_r;
    seen_nxt  = seen_r;
    evt       = '0;
    evt_vld   = 1'b0;
    fail_en   = 1'b0;
    fail_code = ivf_pkg::ERR_NONE;
    do_reset  = 1'b0;

    unique case (phase_r)
      PH_HEAD: begin
        if ((fidx_r < ivf_pkg::IDX_MAGIC_END) &&
            (in_tdata != ivf_pkg::MAGIC[8*fidx_r[1:0] +: 8])) begin
          fail_en   = 1'b1;
          fail_code = ivf_pkg::ERR_MAGIC;
        end else if (fidx_r < ivf_pkg::IDX_HDR_LAST) begin
          fidx_nxt = fidx_r + 5'd1;
          if (in_tlast) begin
            fail_en   = 1'b1;
            fail_code = ivf_pkg::ERR_MAGIC;
          end
        end else begin
          hlen_nxt = h_len;
          if (h_bad) begin
            fail_en   = 1'b1;
            fail_code = ivf_pkg::ERR_HEADER;
          end else if (in_tlast) begin
            fail_en   = 1'b1;
            fail_code = (h_len == ivf_pkg::HDR_LEN) ? ivf_pkg::ERR_NO_FRAMES
                                                    : ivf_pkg::ERR_HEADER;
          end else begin
            evt_vld                = 1'b1;
            evt.rec.kind           = ivf_pkg::KIND_HEADER;
            evt.rec.codec_fourcc   = h_cc;
            evt.rec.frame_width    = h_w;
            evt.rec.frame_height   = h_h;
            evt.rec.time_rate      = h_rate;
            evt.rec.time_scale     = h_scale;
            evt.rec.declared_count = h_cnt;
            fidx_nxt  = '0;
            phase_nxt = (h_len == ivf_pkg::HDR_LEN) ? PH_FHDR : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (OW'(pos_inc) == OW'(hlen_r)) begin
          if (in_tlast) begin
            fail_en   = 1'b1;
            fail_code = seen_r ? ivf_pkg::ERR_HEADER : ivf_pkg::ERR_NO_FRAMES;
          end else begin
            fidx_nxt  = '0;
            phase_nxt = PH_FHDR;
          end
        end else if (in_tlast) begin
          fail_en   = 1'b1;
          fail_code = ivf_pkg::ERR_HEADER;
        end
      end
      PH_FHDR: begin
        // each byte lands in a fresh lane; the first byte clears the word
        if (fidx_r < ivf_pkg::IDX_LEN_END) begin
          if (fidx_r == '0) flen_nxt = '0;
          flen_nxt[8*fidx_r[1:0] +: 8] = in_tdata;
        end else if (fidx_r <= ivf_pkg::IDX_FHDR_LAST) begin
          if (fidx_r == ivf_pkg::IDX_LEN_END) ftime_nxt = '0;
          ftime_nxt[8*hb_addr[2:0] +: 8] = in_tdata;
        end
        if (fidx_r >= ivf_pkg::IDX_FHDR_LAST) begin
          if ((flen_r == '0) || in_tlast) begin
            fail_en   = 1'b1;
            fail_code = ivf_pkg::ERR_FSIZE;
          end else begin
            rem_nxt   = flen_r;
            phase_nxt = PH_PAY;
          end
        end else begin
          fidx_nxt = fidx_r + 5'd1;
          if (in_tlast) begin
            fail_en   = 1'b1;
            fail_code = ivf_pkg::ERR_FHDR;
          end
        end
      end
      PH_PAY: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          evt_vld                 = 1'b1;
          evt.rec.kind            = ivf_pkg::KIND_FRAME;
          evt.rec.payload_offset  = 32'(off_w[OFFSET_BITS-1:0]);
          evt.rec.payload_size    = flen_r;
          evt.rec.frame_timestamp = ftime_r;
          seen_nxt = 1'b1;
          if (in_tlast) begin
            evt.pair = 1'b1;
            do_reset = 1'b1;
          end else begin
            fidx_nxt  = '0;
            phase_nxt = PH_FHDR;
          end
        end else if (in_tlast) begin
          fail_en   = 1'b1;
          fail_code = ivf_pkg::ERR_FSIZE;
        end
      end
      PH_DRAIN: begin
        if (in_tlast) do_reset = 1'b1;
      end
      default: begin
        phase_nxt = PH_DRAIN;
      end
    endcase

    if (fail_en) begin
      evt       = '0;
      evt_vld   = 1'b1;
      evt.rec.kind = ivf_pkg::KIND_ERROR;
      evt.rec.err  = fail_code;
      if (in_tlast) do_reset = 1'b1;
      else phase_nxt = PH_DRAIN;
    end

    // end of file: back to the reset state for the next file
    if (do_reset) begin
      phase_nxt = PH_HEAD;
      fidx_nxt  = '0;
      hlen_nxt  = '0;
      pos_nxt   = '0;
      flen_nxt  = '0;
      ftime_nxt = '0;
      rem_nxt   = '0;
      seen_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
      fidx_r  <= '0;
      hlen_r  <= '0;
      pos_r   <= '0;
      flen_r  <= '0;
      ftime_r <= '0;
      rem_r   <= '0;
      seen_r  <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      fidx_r  <= fidx_nxt;
      hlen_r  <= hlen_nxt;
      pos_r   <= pos_nxt;
      flen_r  <= flen_nxt;
      ftime_r <= ftime_nxt;
      rem_r   <= rem_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hb_we) hb_r[hb_addr] <= in_tdata;
  end

`ifndef SYNTH
  a_hdr_fields_ok: assert property (@(posedge clk) disable iff (!rst_n)
    push && evt.rec.kind == ivf_pkg::KIND_HEADER |->
      evt.rec.frame_width != '0 && evt.rec.time_scale != '0)
    else $error("header record with zero width or scale");
  a_fidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FHDR |-> fidx_r <= ivf_pkg::IDX_FHDR_LAST)
    else $error("frame header index out of range");
`endif

endmodule

### src/ivf_evq.sv
// ----------------------------------------------------------------------------
// ivf_evq: event queue between parser and record output
// Four-entry FIFO of events; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module ivf_evq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ivf_pkg::evt_t      push_evt,
  input  logic               pop,
  output ivf_pkg::evt_t      head,
  output ivf_pkg::evq_stat_t stat
);

  localparam int AW = $clog2(ivf_pkg::EVQ_DEPTH);
  localparam logic [AW:0] DEPTH_C = (AW+1)'(ivf_pkg::EVQ_DEPTH);

  ivf_pkg::evt_t mem_r [ivf_pkg::EVQ_DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [AW:0]   count_r;

  assign head       = mem_r[rptr_r];
  assign stat.full  = (count_r == DEPTH_C);
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop) rptr_r <= rptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_evt;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("event queue count exceeds depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full || pop)
    else $error("push into full event queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty event queue");
`endif

endmodule

### src/ivf_back.sv
// ----------------------------------------------------------------------------
// ivf_back: record output stage
// Turns queued events into output words; a frame that closes the file is
// followed by an end record. Holds the word until the consumer takes it.
// ----------------------------------------------------------------------------
module ivf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ivf_pkg::evt_t      head,
  input  ivf_pkg::evq_stat_t q_stat,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output ivf_pkg::rec_t      out_rec,
  output logic               out_last
);

  logic          out_valid_r;
  logic          second_r;
  ivf_pkg::rec_t rec_r;
  logic          last_r;
  ivf_pkg::rec_t end_rec;
  logic          load;

  assign out_tvalid = out_valid_r;
  assign out_rec    = rec_r;
  assign out_last   = last_r;

  assign load = !q_stat.empty && (!out_valid_r || out_tready);
  assign pop  = load && (!head.pair || second_r);

  always_comb begin
    end_rec      = '0;
    end_rec.kind = ivf_pkg::KIND_END;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      second_r    <= head.pair && !second_r;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (second_r) begin
        rec_r  <= end_rec;
        last_r <= 1'b1;
      end else begin
        rec_r  <= head.rec;
        last_r <= !head.pair;
      end
    end
  end

`ifndef SYNTH
  a_pair_frame_shown: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> out_valid_r && rec_r.kind == ivf_pkg::KIND_FRAME && !last_r)
    else $error("end record pending without frame word on output");
`endif

endmodule

### test/ivf_container_parser_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ivf_container_parser_top_tb: self-checking bench for the IVF container parser
// Streams whole IVF files byte by byte, parses them again in the bench and
// checks every header, frame, end and error record the block puts out.
// ----------------------------------------------------------------------------
module ivf_container_parser_top_tb;

  localparam int RANDOM_BYTES = 2000;
  localparam int TAIL_BYTES   = 200;
  localparam int MAX_PRINTS   = 100;

  typedef enum logic [2:0] {
    PS_HEAD,
    PS_SKIP,
    PS_FHDR,
    PS_PAY,
    PS_DRAIN
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  typedef struct packed {
    ivf_pkg::kind_t kind;
    ivf_pkg::err_t  err;
    logic [31:0]    fourcc;
    logic [15:0]    width;
    logic [15:0]    height;
    logic [31:0]    rate;
    logic [31:0]    scale;
    logic [31:0]    count;
    logic [31:0]    offset;
    logic [31:0]    size;
    logic [63:0]    stamp;
    logic           last;
  } ivf_rec_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [7:0]                  in_tdata = 8'd0;
  logic                        in_tlast = 1'b0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [ivf_pkg::TDATA_W-1:0] out_tdata;
  logic [1:0]                  out_tuser;
  logic                        out_tlast;

  ivf_container_parser_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  in_word_t    file_bytes[$];
  logic [7:0]  file_buf[$];
  ivf_rec_t    pending_records[$];
  ivf_rec_t    byte_recs[$];
  int          mismatch_count = 0;

  // bench copy of the parser state
  parse_state_t ps = PS_HEAD;
  logic [4:0]   ps_index = '0;
  logic [7:0]   hdr_store [0:ivf_pkg::HB_DEPTH-1];
  logic [15:0]  hdr_len = '0;
  logic [31:0]  byte_pos = '0;
  logic [31:0]  frame_len = '0;
  logic [63:0]  frame_time = '0;
  logic [31:0]  pay_left = '0;
  logic         frame_seen = 1'b0;

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) flag_mismatch($sformatf("%s: got %0h, want %0h", name, got, want));
  endtask

  task automatic clear_parser();
    ps = PS_HEAD;
    ps_index = '0;
    for (int i = 0; i < ivf_pkg::HB_DEPTH; i++) hdr_store[i] = 8'd0;
    hdr_len = '0;
    byte_pos = '0;
    frame_len = '0;
    frame_time = '0;
    pay_left = '0;
    frame_seen = 1'b0;
  endtask

  function automatic logic [63:0] hdr_field(input int at, input int len);
    logic [63:0] v;
    v = '0;
    for (int i = len - 1; i >= 0; i--)
      v = (v << 8) | hdr_store[(at + i) % ivf_pkg::HB_DEPTH];
    return v;
  endfunction

  task automatic push_error(input ivf_pkg::err_t code, input logic last);
    ivf_rec_t r;
    r = '0;
    r.kind = ivf_pkg::KIND_ERROR;
    r.err = code;
    byte_recs.push_back(r);
    if (last) clear_parser();
    else ps = PS_DRAIN;
  endtask

  // parse one accepted byte, queue the records it produces
  task automatic ivf_parse_byte(input logic [7:0] b, input logic last);
    ivf_rec_t    r;
    logic [31:0] p;
    logic [4:0]  idx;
    logic [15:0] hl;
    p = byte_pos;
    idx = ps_index;
    byte_pos = byte_pos + 32'd1;
    case (ps)
      PS_HEAD: begin
        if (idx < ivf_pkg::IDX_MAGIC_END && b != ivf_pkg::MAGIC[8*idx +: 8]) begin
          push_error(ivf_pkg::ERR_MAGIC, last);
        end else begin
          if (idx >= ivf_pkg::IDX_MAGIC_END && idx < ivf_pkg::IDX_HB_END)
            hdr_store[idx - ivf_pkg::IDX_MAGIC_END] = b;
          if (idx < ivf_pkg::IDX_HDR_LAST) begin
            ps_index = idx + 5'd1;
            if (last) push_error(ivf_pkg::ERR_MAGIC, last);
          end else begin
            hl = 16'(hdr_field(2, 2));
            hdr_len = hl;
            if (hdr_field(0, 2) != 0 || hl < ivf_pkg::HDR_LEN || hdr_field(8, 2) == 0 ||
                hdr_field(10, 2) == 0 || hdr_field(12, 4) == 0 ||
                hdr_field(16, 4) == 0) begin
              push_error(ivf_pkg::ERR_HEADER, last);
            end else if (last) begin
              push_error(hl == ivf_pkg::HDR_LEN ? ivf_pkg::ERR_NO_FRAMES
                                                : ivf_pkg::ERR_HEADER, last);
            end else begin
              r = '0;
              r.kind = ivf_pkg::KIND_HEADER;
              r.err = ivf_pkg::ERR_NONE;
              r.fourcc = 32'(hdr_field(4, 4));
              r.width = 16'(hdr_field(8, 2));
              r.height = 16'(hdr_field(10, 2));
              r.rate = 32'(hdr_field(12, 4));
              r.scale = 32'(hdr_field(16, 4));
              r.count = 32'(hdr_field(20, 4));
              byte_recs.push_back(r);
              ps_index = '0;
              ps = (hl == ivf_pkg::HDR_LEN) ? PS_FHDR : PS_SKIP;
            end
          end
        end
      end
      PS_SKIP: begin
        if (({1'b0, p} + 33'd1) == {17'd0, hdr_len}) begin
          if (last) begin
            push_error(frame_seen ? ivf_pkg::ERR_HEADER : ivf_pkg::ERR_NO_FRAMES, last);
          end else begin
            ps_index = '0;
            ps = PS_FHDR;
          end
        end else if (last) begin
          push_error(ivf_pkg::ERR_HEADER, last);
        end
      end
      PS_FHDR: begin
        if (idx < ivf_pkg::IDX_LEN_END) begin
          frame_len = (idx == 0 ? 32'd0 : frame_len) | ({24'd0, b} << (8 * idx));
        end else if (idx <= ivf_pkg::IDX_FHDR_LAST) begin
          frame_time = (idx == ivf_pkg::IDX_LEN_END ? 64'd0 : frame_time) |
                       ({56'd0, b} << (8 * (idx - ivf_pkg::IDX_LEN_END)));
        end
        if (idx >= ivf_pkg::IDX_FHDR_LAST) begin
          if (frame_len == 0 || last) begin
            push_error(ivf_pkg::ERR_FSIZE, last);
          end else begin
            pay_left = frame_len;
            ps = PS_PAY;
          end
        end else begin
          ps_index = idx + 5'd1;
          if (last) push_error(ivf_pkg::ERR_FHDR, last);
        end
      end
      PS_PAY: begin
        pay_left = pay_left - 32'd1;
        if (pay_left == 0) begin
          r = '0;
          r.kind = ivf_pkg::KIND_FRAME;
          r.err = ivf_pkg::ERR_NONE;
          r.offset = p + 32'd1 - frame_len;
          r.size = frame_len;
          r.stamp = frame_time;
          byte_recs.push_back(r);
          frame_seen = 1'b1;
          if (last) begin
            r = '0;
            r.kind = ivf_pkg::KIND_END;
            r.err = ivf_pkg::ERR_NONE;
            byte_recs.push_back(r);
            clear_parser();
          end else begin
            ps_index = '0;
            ps = PS_FHDR;
          end
        end else if (last) begin
          push_error(ivf_pkg::ERR_FSIZE, last);
        end
      end
      default: begin
        // drop everything up to and including the end of this file
        if (last) clear_parser();
      end
    endcase
    for (int i = 0; i < byte_recs.size(); i++) begin
      r = byte_recs[i];
      r.last = (i == byte_recs.size() - 1);
      pending_records.push_back(r);
    end
    byte_recs.delete();
  endtask

  // ---- file building ----
  function automatic logic [15:0] pick_nz16();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic logic [31:0] pick_nz32();
    logic [31:0] v;
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
    v = $urandom;
    return (v == 0) ? 32'd1 : v;
  endfunction

  task automatic add_le(input logic [63:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) file_buf.push_back(v[8*i +: 8]);
  endtask

  task automatic add_header(input logic [15:0] hl, input logic [31:0] fourcc,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [31:0] rate, input logic [31:0] scale,
                            input logic [31:0] count);
    add_le(64'(ivf_pkg::MAGIC), 4);
    add_le(64'd0, 2);
    add_le(64'(hl), 2);
    add_le(64'(fourcc), 4);
    add_le(64'(w), 2);
    add_le(64'(h), 2);
    add_le(64'(rate), 4);
    add_le(64'(scale), 4);
    add_le(64'(count), 4);
    add_le(64'($urandom), 4);
    for (int i = 32; i < hl; i++) file_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_plain_header(input logic [15:0] hl);
    add_header(hl, $urandom, pick_nz16(), pick_nz16(), pick_nz32(), pick_nz32(), $urandom);
  endtask

  task automatic add_frame(input logic [31:0] size, input logic [63:0] stamp);
    add_le(64'(size), 4);
    add_le(stamp, 8);
    for (int i = 0; i < size; i++) file_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic truncate_to(input int n);
    while (file_buf.size() > n) void'(file_buf.pop_back());
  endtask

  task automatic emit_file();
    in_word_t w;
    for (int i = 0; i < file_buf.size(); i++) begin
      w.data = file_buf[i];
      w.last = (i == file_buf.size() - 1);
      file_bytes.push_back(w);
    end
    file_buf.delete();
  endtask

  task automatic add_random_file();
    int          sel;
    int          at;
    int          len;
    int          nfr;
    logic [15:0] hl;
    logic [31:0] size;
    sel = $urandom_range(0, 9);
    if ($urandom_range(0, 19) == 0) hl = 16'($urandom_range(49, 300));
    else if ($urandom_range(0, 3) == 0) hl = 16'($urandom_range(33, 48));
    else hl = ivf_pkg::HDR_LEN;
    add_plain_header(hl);
    nfr = $urandom_range(1, 4);
    for (int f = 0; f < nfr; f++) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 300) : $urandom_range(1, 8);
      add_frame(size, {$urandom, $urandom});
    end
    case (sel)
      7: begin
        case ($urandom_range(0, 3))
          0: file_buf[$urandom_range(0, 31)] = 8'($urandom_range(0, 255));
          1: begin
            at = $urandom_range(0, 3);
            len = (at < 2) ? 2 : 4;
            at = (at < 2) ? 12 + 2 * at : 16 + 4 * (at - 2);
            for (int i = 0; i < len; i++) file_buf[at + i] = 8'd0;
          end
          2: for (int i = 0; i < 4; i++) file_buf[hl + i] = 8'd0;
          default: begin
            file_buf[6] = 8'($urandom_range(0, 31));
            file_buf[7] = 8'd0;
          end
        endcase
      end
      8: truncate_to($urandom_range(1, file_buf.size() - 1));
      9: begin
        file_buf.delete();
        if ($urandom_range(0, 1)) add_le(64'(ivf_pkg::MAGIC), $urandom_range(1, 4));
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) file_buf.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    emit_file();
  endtask

  // ---- input side ----
  int   in_gap = 0;
  logic in_calm = 1'b0;

  always @(posedge clk) begin : drive_in
    in_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'd0;
      in_tlast <= 1'b0;
      in_gap = 0;
      clear_parser();
    end else begin
      if (in_tvalid && in_tready) ivf_parse_byte(in_tdata, in_tlast);
      if ($urandom_range(0, 63) == 0) in_calm = ~in_calm;
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (file_bytes.size() > 0) begin
          w = file_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= w.data;
          in_tlast <= w.last;
          if (!in_calm && file_bytes.size() > TAIL_BYTES && $urandom_range(0, 3) == 0)
            in_gap = $urandom_range(1, 6);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- output side ----
  int   out_stall = 0;
  logic out_calm = 1'b0;

  always @(posedge clk) begin : drive_out
    if ($urandom_range(0, 63) == 0) out_calm = ~out_calm;
    if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else if (!out_calm && file_bytes.size() > TAIL_BYTES && $urandom_range(0, 4) == 0) begin
      out_stall = $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_out
    ivf_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_records.size() == 0) begin
        flag_mismatch($sformatf("record of kind %0d with nothing pending", out_tuser));
      end else begin
        want = pending_records.pop_front();
        check_field("record_kind", 64'(out_tuser), 64'(want.kind));
        check_field("error_code", 64'(out_tdata[2:0]), 64'(want.err));
        check_field("codec_fourcc", 64'(out_tdata[34:3]), 64'(want.fourcc));
        check_field("frame_width", 64'(out_tdata[50:35]), 64'(want.width));
        check_field("frame_height", 64'(out_tdata[66:51]), 64'(want.height));
        check_field("time_rate", 64'(out_tdata[98:67]), 64'(want.rate));
        check_field("time_scale", 64'(out_tdata[130:99]), 64'(want.scale));
        check_field("declared_count", 64'(out_tdata[162:131]), 64'(want.count));
        check_field("payload_offset", 64'(out_tdata[194:163]), 64'(want.offset));
        check_field("payload_size", 64'(out_tdata[226:195]), 64'(want.size));
        check_field("frame_timestamp", out_tdata[290:227], want.stamp);
        check_field("zero_fill", 64'(out_tdata[ivf_pkg::TDATA_W-1:291]), 64'd0);
        check_field("last_of_run", 64'(out_tlast), 64'(want.last));
      end
    end
  end

  // ---- stimulus and end of run ----
  initial begin
    // smallest good file, header values at their extremes
    add_header(ivf_pkg::HDR_LEN, 32'hFFFF_FFFF, 16'hFFFF, 16'd1, 32'hFFFF_FFFF, 32'd1,
               32'd0);
    add_frame(32'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    emit_file();
    add_header(ivf_pkg::HDR_LEN, 32'd0, 16'd1, 16'hFFFF, 32'd1, 32'hFFFF_FFFF,
               32'hFFFF_FFFF);
    add_frame(32'd2, 64'd0);
    add_frame(32'd3, {$urandom, $urandom});
    emit_file();
    // wrong magic byte, rest of the file drained
    add_plain_header(ivf_pkg::HDR_LEN);
    file_buf[2] = 8'h00;
    add_frame(32'd4, {$urandom, $urandom});
    emit_file();
    // one-byte file
    file_buf.push_back(ivf_pkg::MAGIC[7:0]);
    emit_file();
    // header only, no frames
    add_plain_header(ivf_pkg::HDR_LEN);
    emit_file();
    // long header, file stops at byte 32
    add_plain_header(16'd34);
    truncate_to(32);
    emit_file();
    // file stops exactly at the end of a long header
    add_plain_header(16'd36);
    emit_file();
    // file stops inside the skipped header tail
    add_plain_header(16'd40);
    truncate_to(37);
    emit_file();
    // nonzero version
    add_plain_header(ivf_pkg::HDR_LEN);
    file_buf[4] = 8'h01;
    add_frame(32'd2, {$urandom, $urandom});
    emit_file();
    // header length below 32
    add_plain_header(16'd31);
    add_frame(32'd2, {$urandom, $urandom});
    emit_file();
    // zero width, then zero scale
    add_header(ivf_pkg::HDR_LEN, $urandom, 16'd0, 16'd5, 32'd7, 32'd9, $urandom);
    add_frame(32'd1, {$urandom, $urandom});
    emit_file();
    add_header(ivf_pkg::HDR_LEN, $urandom, 16'd5, 16'd5, 32'd7, 32'd0, $urandom);
    emit_file();
    // zero frame size with more data behind it, then at the very end
    add_plain_header(ivf_pkg::HDR_LEN);
    add_frame(32'd0, {$urandom, $urandom});
    add_frame(32'd2, {$urandom, $urandom});
    emit_file();
    add_plain_header(ivf_pkg::HDR_LEN);
    add_frame(32'd0, {$urandom, $urandom});
    emit_file();
    // truncated frame header, frame header ending the file, short payload
    add_plain_header(ivf_pkg::HDR_LEN);
    add_frame(32'd5, {$urandom, $urandom});
    truncate_to(38);
    emit_file();
    add_plain_header(ivf_pkg::HDR_LEN);
    add_frame(32'd5, {$urandom, $urandom});
    truncate_to(44);
    emit_file();
    add_plain_header(ivf_pkg::HDR_LEN);
    add_frame(32'd5, {$urandom, $urandom});
    truncate_to(47);
    emit_file();

    len_loop: while (file_bytes.size() < RANDOM_BYTES) add_random_file();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (file_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
